>>> rtl/tlpa_pkg.sv
// Package for the two-list page aging block.
// Shared constants, field widths and the per-page cell command struct.
package tlpa_pkg;

  localparam int NumPagesDef  = 32;
  localparam int CountBitsDef = 16;

  localparam int ActionW = 2;
  localparam int PageW   = 5;
  localparam int SizeW   = 6;
  localparam int TotalW  = 16;
  localparam int CfgIdxW = 2;

  // Action codes
  localparam logic [ActionW-1:0] ActAccess = 2'd0;
  localparam logic [ActionW-1:0] ActScan   = 2'd1;
  localparam logic [ActionW-1:0] ActQuery  = 2'd2;
  localparam logic [ActionW-1:0] ActDump   = 2'd3;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegActiveLimit = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDemoteCount = 2'd1;

  // Command to one page cell
  typedef struct packed {
    logic we_next;   // write link at next address
    logic set_act;   // mark active, at record address
    logic clr_act;   // mark inactive
    logic set_ref;   // set referenced mark
    logic credit;    // add one credit if referenced, clear mark
  } tlpa_cmd_t;

endpackage

>>> rtl/tlpa_cell.sv
// One page cell: link, active mark, referenced mark and saturating credits.
// Uses tlpa_pkg for the command struct.
module tlpa_cell
  import tlpa_pkg::*;
#(
  parameter int NUM_PAGES  = NumPagesDef,
  parameter int COUNT_BITS = CountBitsDef,
  parameter int INDEX      = 0,
  parameter int IW         = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tlpa_cmd_t             cmd_i,
  input  logic [IW-1:0]         next_addr_i,
  input  logic [IW-1:0]         rec_addr_i,
  input  logic [IW-1:0]         next_val_i,
  output logic [IW-1:0]         next_o,
  output logic                  act_o,
  output logic                  ref_o,
  output logic [COUNT_BITS-1:0] cnt_o
);

  localparam logic [IW-1:0] MyIdx   = IW'(INDEX);
  localparam logic [IW-1:0] RstNext = (INDEX + 1 < NUM_PAGES) ? IW'(INDEX + 1) : '0;

  logic [IW-1:0]         next_q;
  logic                  act_q, ref_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic                  hit_next, hit_rec;

  assign hit_next = (next_addr_i == MyIdx);
  assign hit_rec  = (rec_addr_i == MyIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q <= RstNext;
      act_q  <= 1'b0;
      ref_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.we_next && hit_next) next_q <= next_val_i;
      if (hit_rec) begin
        if (cmd_i.set_act) act_q <= 1'b1;
        if (cmd_i.clr_act) act_q <= 1'b0;
        if (cmd_i.set_ref) ref_q <= 1'b1;
        if (cmd_i.credit && ref_q) begin
          ref_q <= 1'b0;
          if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign next_o = next_q;
  assign act_o  = act_q;
  assign ref_o  = ref_q;
  assign cnt_o  = cnt_q;

endmodule

>>> rtl/two_list_page_aging.sv
// Two-list page aging: top level with list sequencer and a row of page cells.
// Depends on tlpa_pkg and tlpa_cell.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_stall_o  | action_i, page_i
//  out     | output    | out_valid_o/out_stall_i| kind_o .. last_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// Query goes straight to the response. Access unlinks an in-range page from
// its list, walking up to NUM_PAGES entries, appends it to the active list and
// demotes up to the demote count from the active head when the active count
// exceeds the limit. Scan credits each referenced active page. Dump gives one
// result per cycle within each list while the output is not stalled. Reset is
// asynchronous and puts all pages in the inactive list in index order.
// A stalled output holds its result; the block waits while it does.
module two_list_page_aging
  import tlpa_pkg::*;
#(
  parameter int NUM_PAGES  = NumPagesDef,
  parameter int COUNT_BITS = CountBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ActionW-1:0] action_i,
  input  logic [PageW-1:0]   page_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ActionW-1:0] kind_o,
  output logic [PageW-1:0]   page_index_o,
  output logic               in_active_o,
  output logic               ref_flag_o,
  output logic [TotalW-1:0]  total_count_o,
  output logic [SizeW-1:0]   demoted_o,
  output logic [SizeW-1:0]   active_size_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SizeW-1:0]   cfg_data_i
);

  localparam int IW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int CW = $clog2(NUM_PAGES + 1);
  localparam logic [SizeW-1:0] LimitRst  = SizeW'((7 * NUM_PAGES) / 10);
  localparam logic [SizeW-1:0] DemoteRst = SizeW'((2 * NUM_PAGES) / 10);

  typedef enum logic [3:0] {
    ST_IDLE, ST_UNLINK, ST_WALK, ST_APPEND, ST_DEM_CHK, ST_DEMOTE,
    ST_SCAN, ST_RESP, ST_DUMP_A, ST_DUMP_I
  } state_e;

  state_e            state_q;
  logic [ActionW-1:0] action_q;
  logic [IW-1:0]     p_q, np_q, prev_q, cur_q;
  logic [PageW-1:0]  page_raw_q;
  logic              oor_q, lsel_q;
  logic [IW-1:0]     ahead_q, atail_q, ihead_q, itail_q;
  logic [CW-1:0]     acnt_q, icnt_q, i_q, k_q, n_q;
  logic [SizeW-1:0]  limit_q, dcount_q;

  logic               ov_q, last_q, oact_q, oref_q;
  logic [ActionW-1:0] okind_q;
  logic [PageW-1:0]   opage_q;
  logic [TotalW-1:0]  ocnt_q;
  logic [SizeW-1:0]   odem_q, osize_q;

  // cell row
  tlpa_cmd_t     cmd;
  logic [IW-1:0] next_addr, rec_addr, next_val;
  logic [IW-1:0]         next_arr [NUM_PAGES];
  logic                  act_arr  [NUM_PAGES];
  logic                  ref_arr  [NUM_PAGES];
  logic [COUNT_BITS-1:0] cnt_arr  [NUM_PAGES];

  for (genvar g = 0; g < NUM_PAGES; g++) begin : g_cell
    tlpa_cell #(
      .NUM_PAGES (NUM_PAGES),
      .COUNT_BITS(COUNT_BITS),
      .INDEX     (g),
      .IW        (IW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .next_addr_i(next_addr),
      .rec_addr_i (rec_addr),
      .next_val_i (next_val),
      .next_o     (next_arr[g]),
      .act_o      (act_arr[g]),
      .ref_o      (ref_arr[g]),
      .cnt_o      (cnt_arr[g])
    );
  end

  logic [IW-1:0] in_pg;
  logic          in_oor, in_acc, out_free, emit;
  logic [IW-1:0] l_head, nxt_prev, nxt_cur;
  logic [CW-1:0] l_cnt;
  logic          dump_more_a, dump_more_i;

  assign in_pg     = IW'(page_i);
  assign in_oor    = (32'(page_i) >= NUM_PAGES);
  assign in_acc    = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !ov_q || !out_stall_i;
  assign l_head    = lsel_q ? ahead_q : ihead_q;
  assign l_cnt     = lsel_q ? acnt_q : icnt_q;
  assign nxt_prev  = next_arr[prev_q];
  assign nxt_cur   = next_arr[cur_q];
  assign dump_more_a = (32'(k_q) + 1 < NUM_PAGES) && ((i_q + 1'b1 < acnt_q) || (icnt_q != '0));
  assign dump_more_i = (32'(k_q) + 1 < NUM_PAGES) && (i_q + 1'b1 < icnt_q);

  // a result is loaded into the output register this cycle
  assign emit = out_free && ((state_q == ST_RESP) ||
                ((state_q == ST_DUMP_A) && (i_q < acnt_q) && (32'(k_q) < NUM_PAGES)) ||
                ((state_q == ST_DUMP_I) && (i_q < icnt_q) && (32'(k_q) < NUM_PAGES)));

  // cell commands
  always_comb begin
    cmd       = '0;
    next_addr = prev_q;
    rec_addr  = p_q;
    next_val  = np_q;
    case (state_q)
      ST_IDLE: begin
        rec_addr    = in_pg;
        cmd.set_ref = in_acc && !in_oor && (action_i == ActAccess);
      end
      ST_WALK: begin
        cmd.we_next = (32'(i_q) < 32'(l_cnt)) && (nxt_prev == p_q);
      end
      ST_APPEND: begin
        next_addr   = atail_q;
        next_val    = p_q;
        cmd.we_next = (acnt_q != '0);
        cmd.set_act = 1'b1;
      end
      ST_DEMOTE: begin
        next_addr   = itail_q;
        next_val    = ahead_q;
        rec_addr    = ahead_q;
        cmd.we_next = (32'(n_q) < 32'(dcount_q)) && (acnt_q != '0) && (icnt_q != '0);
        cmd.clr_act = (32'(n_q) < 32'(dcount_q)) && (acnt_q != '0);
      end
      ST_SCAN: begin
        rec_addr   = cur_q;
        cmd.credit = (i_q < acnt_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ahead_q  <= '0;
      atail_q  <= '0;
      ihead_q  <= '0;
      itail_q  <= IW'(NUM_PAGES - 1);
      acnt_q   <= '0;
      icnt_q   <= CW'(NUM_PAGES);
      limit_q  <= LimitRst;
      dcount_q <= DemoteRst;
      ov_q     <= 1'b0;
      action_q <= ActAccess;
      lsel_q   <= 1'b0;
      oor_q    <= 1'b0;
      i_q      <= '0;
      k_q      <= '0;
      n_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == RegActiveLimit) limit_q <= cfg_data_i;
        if (cfg_index_i == RegDemoteCount) dcount_q <= cfg_data_i;
      end
      if (emit) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            action_q   <= action_i;
            p_q        <= in_pg;
            page_raw_q <= page_i;
            oor_q      <= in_oor;
            np_q       <= next_arr[in_pg];
            lsel_q     <= act_arr[in_pg];
            n_q        <= '0;
            i_q        <= '0;
            k_q        <= '0;
            cur_q      <= ahead_q;
            case (action_i)
              ActAccess: state_q <= in_oor ? ST_RESP : ST_UNLINK;
              ActScan:   state_q <= ST_SCAN;
              ActQuery:  state_q <= ST_RESP;
              default:   state_q <= ST_DUMP_A;
            endcase
          end
        end
        ST_UNLINK: begin
          if (l_cnt == '0) begin
            state_q <= ST_APPEND;
          end else if (l_head == p_q) begin
            if (lsel_q) begin
              ahead_q <= np_q;
              acnt_q  <= acnt_q - 1'b1;
            end else begin
              ihead_q <= np_q;
              icnt_q  <= icnt_q - 1'b1;
            end
            state_q <= ST_APPEND;
          end else begin
            prev_q  <= l_head;
            i_q     <= CW'(1);
            state_q <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (i_q >= l_cnt) begin
            state_q <= ST_APPEND;
          end else if (nxt_prev == p_q) begin
            if (lsel_q) begin
              if (atail_q == p_q) atail_q <= prev_q;
              acnt_q <= acnt_q - 1'b1;
            end else begin
              if (itail_q == p_q) itail_q <= prev_q;
              icnt_q <= icnt_q - 1'b1;
            end
            state_q <= ST_APPEND;
          end else begin
            prev_q <= nxt_prev;
            i_q    <= i_q + 1'b1;
          end
        end
        ST_APPEND: begin
          if (acnt_q == '0) ahead_q <= p_q;
          atail_q <= p_q;
          acnt_q  <= acnt_q + 1'b1;
          state_q <= ST_DEM_CHK;
        end
        ST_DEM_CHK: begin
          state_q <= (32'(acnt_q) > 32'(limit_q)) ? ST_DEMOTE : ST_RESP;
        end
        ST_DEMOTE: begin
          if ((32'(n_q) < 32'(dcount_q)) && (acnt_q != '0)) begin
            ahead_q <= next_arr[ahead_q];
            acnt_q  <= acnt_q - 1'b1;
            if (icnt_q == '0) ihead_q <= ahead_q;
            itail_q <= ahead_q;
            icnt_q  <= icnt_q + 1'b1;
            n_q     <= n_q + 1'b1;
          end else begin
            state_q <= ST_RESP;
          end
        end
        ST_SCAN: begin
          if (i_q < acnt_q) begin
            if (ref_arr[cur_q]) n_q <= n_q + 1'b1;
            cur_q <= nxt_cur;
            i_q   <= i_q + 1'b1;
          end else begin
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            okind_q <= action_q;
            last_q  <= 1'b1;
            odem_q  <= SizeW'(n_q);
            osize_q <= SizeW'(acnt_q);
            if (action_q == ActScan || oor_q) begin
              opage_q <= (action_q == ActScan) ? '0 : page_raw_q;
              oact_q  <= 1'b0;
              oref_q  <= 1'b0;
              ocnt_q  <= '0;
            end else begin
              opage_q <= PageW'(p_q);
              oact_q  <= act_arr[p_q];
              oref_q  <= ref_arr[p_q];
              ocnt_q  <= TotalW'(cnt_arr[p_q]);
            end
            state_q <= ST_IDLE;
          end
        end
        ST_DUMP_A, ST_DUMP_I: begin
          if ((state_q == ST_DUMP_A) ? ((i_q < acnt_q) && (32'(k_q) < NUM_PAGES))
                                     : ((i_q < icnt_q) && (32'(k_q) < NUM_PAGES))) begin
            if (out_free) begin
              okind_q <= ActDump;
              opage_q <= PageW'(cur_q);
              oact_q  <= act_arr[cur_q];
              oref_q  <= ref_arr[cur_q];
              ocnt_q  <= TotalW'(cnt_arr[cur_q]);
              odem_q  <= '0;
              osize_q <= SizeW'(acnt_q);
              last_q  <= (state_q == ST_DUMP_A) ? !dump_more_a : !dump_more_i;
              cur_q   <= nxt_cur;
              i_q     <= i_q + 1'b1;
              k_q     <= k_q + 1'b1;
            end
          end else if (state_q == ST_DUMP_A) begin
            cur_q   <= ihead_q;
            i_q     <= '0;
            state_q <= ST_DUMP_I;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = ov_q;
  assign kind_o        = okind_q;
  assign page_index_o  = opage_q;
  assign in_active_o   = oact_q;
  assign ref_flag_o    = oref_q;
  assign total_count_o = ocnt_q;
  assign demoted_o     = odem_q;
  assign active_size_o = osize_q;
  assign last_o        = last_q;

  // both lists together always hold every page between transactions
  a_pool_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (32'(acnt_q) + 32'(icnt_q) == NUM_PAGES))
    else $error("list counts lost a page");

  a_active_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(acnt_q) <= NUM_PAGES)
    else $error("active count overflow");

  a_scan_credits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (n_q <= i_q))
    else $error("scan credited more pages than visited");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && out_free) |=> (state_q == ST_IDLE && ov_q))
    else $error("response not issued");

endmodule
